[rtl/core/mhct_pkg.sv]
// ----------------------------------------------------------------------------
// mhct_pkg
// Shared types, constants and the bucket hash of the MAC hit count table.
// ----------------------------------------------------------------------------
package mhct_pkg;

  // Default geometry.
  localparam int BUCKETS_DEF = 1024;
  localparam int TABLES_DEF  = 4;
  localparam int WAYS_DEF    = 4;

  // Field widths.
  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int HITS_W   = 2;
  localparam int TSEL_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 15;
  localparam int CIDX_W   = 8;
  localparam int CDATA_W  = 32;
  localparam int FOLD_W   = 18;

  // Register reset values.
  localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd15000;
  localparam logic [HITS_W-1:0] REL_HITS_RST  = 2'd2;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_AGE_LIMIT = 8'd0;
  localparam logic [CIDX_W-1:0] REG_REL_HITS  = 8'd1;

  // Request types.
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_SWEEP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SWEPT    = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One table entry.
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [HITS_W-1:0] hits;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Shift-xor fold of the six MAC bytes, first byte most significant.
  function automatic logic [FOLD_W-1:0] mac_fold(input logic [MAC_W-1:0] mac);
    logic [FOLD_W-1:0] x;
    x = FOLD_W'(mac[47:40]);
    for (int i = 4; i >= 0; i--) begin
      x = (x << 2) ^ FOLD_W'(mac[i*8 +: 8]);
    end
    mac_fold = x ^ (x >> 8);
  endfunction

endpackage

[rtl/core/mhct_if.sv]
// ----------------------------------------------------------------------------
// mhct_if
// Request, result and configuration channels of the MAC hit count table.
// ----------------------------------------------------------------------------
interface mhct_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [mhct_pkg::TSEL_W-1:0]     table_sel;
  logic [mhct_pkg::MAC_W-1:0]      mac_addr;
  logic [mhct_pkg::TIME_W-1:0]     now_ms;
  modport source (output valid, req_type, table_sel, mac_addr, now_ms, input ready);
  modport sink   (input valid, req_type, table_sel, mac_addr, now_ms, output ready);
endinterface

interface mhct_out_if;
  logic                            valid;
  logic                            ready;
  logic [mhct_pkg::STATUS_W-1:0]   status;
  logic [mhct_pkg::COUNT_W-1:0]    aged_count;
  modport source (output valid, status, aged_count, input ready);
  modport sink   (input valid, status, aged_count, output ready);
endinterface

interface mhct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mhct_pkg::CIDX_W-1:0]     addr;
  logic [mhct_pkg::CDATA_W-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/core/mhct_mem.sv]
// ----------------------------------------------------------------------------
// mhct_mem
// Bucket memory: one row holds all ways of one bucket, registered read.
// ----------------------------------------------------------------------------
module mhct_mem #(
  parameter int ROWS = mhct_pkg::TABLES_DEF * mhct_pkg::BUCKETS_DEF,
  parameter int WAYS = mhct_pkg::WAYS_DEF,
  localparam int ROW_W = $clog2(ROWS)
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [ROW_W-1:0]                 rd_addr,
  output mhct_pkg::entry_t [WAYS-1:0]      rd_data_r,
  input  logic                             wr_en,
  input  logic [ROW_W-1:0]                 wr_addr,
  input  mhct_pkg::entry_t [WAYS-1:0]      wr_data
);

  mhct_pkg::entry_t [WAYS-1:0] mem [ROWS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/mhct_ctrl.sv]
// ----------------------------------------------------------------------------
// mhct_ctrl
// Sequencer: clearing pass, bucket read-modify-write, row sweep, result register.
// ----------------------------------------------------------------------------
module mhct_ctrl #(
  parameter int BUCKETS = mhct_pkg::BUCKETS_DEF,
  parameter int TABLES  = mhct_pkg::TABLES_DEF,
  parameter int WAYS    = mhct_pkg::WAYS_DEF,
  localparam int ROWS  = TABLES * BUCKETS,
  localparam int ROW_W = $clog2(ROWS),
  localparam int BKT_W = $clog2(BUCKETS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mhct_in_if.sink                       in_ch,
  mhct_out_if.source                    out_ch,
  mhct_cfg_if.sink                      cfg_ch,
  output logic                          rd_en,
  output logic [ROW_W-1:0]              rd_addr,
  input  mhct_pkg::entry_t [WAYS-1:0]   rd_data,
  output logic                          wr_en,
  output logic [ROW_W-1:0]              wr_addr,
  output mhct_pkg::entry_t [WAYS-1:0]   wr_data
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam int               POP_W    = $clog2(WAYS + 1);

  logic [2:0]                      state_r, state_nxt;
  logic [ROW_W-1:0]                row_r, row_nxt;
  logic [mhct_pkg::MAC_W-1:0]      mac_r;
  logic [mhct_pkg::TIME_W-1:0]     now_r;
  logic [mhct_pkg::STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [mhct_pkg::COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [mhct_pkg::TIME_W-1:0]     age_limit_r;
  logic [mhct_pkg::HITS_W-1:0]     rel_hits_r;
  logic                            out_valid_r;
  logic [mhct_pkg::STATUS_W-1:0]   out_st_r;
  logic [mhct_pkg::COUNT_W-1:0]    out_cnt_r;

  logic                            in_acc;
  logic [mhct_pkg::FOLD_W-1:0]     fold;
  logic [ROW_W-1:0]                in_row;
  logic                            out_load;

  mhct_pkg::entry_t [WAYS-1:0]     acc_row;
  mhct_pkg::entry_t [WAYS-1:0]     swp_row;
  logic [mhct_pkg::STATUS_W-1:0]   acc_st;
  logic [POP_W-1:0]                removed;
  logic [mhct_pkg::COUNT_W:0]      cnt_sum;

  // Configuration registers; writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= mhct_pkg::AGE_LIMIT_RST;
      rel_hits_r  <= mhct_pkg::REL_HITS_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == mhct_pkg::REG_AGE_LIMIT) begin
        age_limit_r <= cfg_ch.data;
      end
      if (cfg_ch.addr == mhct_pkg::REG_REL_HITS) begin
        rel_hits_r <= cfg_ch.data[mhct_pkg::HITS_W-1:0];
      end
    end
  end

  // Bucket address of the incoming request.
  assign fold   = mhct_pkg::mac_fold(in_ch.mac_addr);
  assign in_row = ROW_W'({in_ch.table_sel, fold[BKT_W-1:0]});

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Access update: first matching way wins, else lowest free way.
  always_comb begin
    logic found;
    logic placed;
    logic [mhct_pkg::HITS_W-1:0] hits_inc;
    acc_row  = rd_data;
    acc_st   = mhct_pkg::ST_DROPPED;
    found    = 1'b0;
    placed   = 1'b0;
    hits_inc = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && rd_data[w].valid && rd_data[w].mac == mac_r) begin
        found    = 1'b1;
        hits_inc = rd_data[w].hits + 1'b1;
        acc_row[w].hits = hits_inc;
        if (hits_inc >= rel_hits_r) begin
          acc_row[w].valid = 1'b0;
          acc_st = mhct_pkg::ST_RELEASED;
        end else begin
          acc_st = mhct_pkg::ST_HIT;
        end
      end
    end
    if (!found) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!placed && !rd_data[w].valid) begin
          placed = 1'b1;
          acc_row[w].valid = 1'b1;
          acc_row[w].mac   = mac_r;
          acc_row[w].hits  = '0;
          acc_row[w].stamp = now_r;
          acc_st = mhct_pkg::ST_INSERTED;
        end
      end
    end
  end

  // Sweep of one row: drop stale entries and count them.
  always_comb begin
    logic stale;
    swp_row = rd_data;
    removed = '0;
    for (int w = 0; w < WAYS; w++) begin
      stale = (now_r < rd_data[w].stamp) ||
              ((now_r - rd_data[w].stamp) >= age_limit_r);
      if (rd_data[w].valid && stale) begin
        swp_row[w].valid = 1'b0;
        removed = removed + 1'b1;
      end
    end
  end

  assign cnt_sum = {1'b0, cnt_r} + (mhct_pkg::COUNT_W + 1)'(removed);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer next state and memory control.
  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    res_st_nxt = res_st_r;
    cnt_nxt    = cnt_r;
    rd_en      = 1'b0;
    rd_addr    = row_r;
    wr_en      = 1'b0;
    wr_addr    = row_r;
    wr_data    = acc_row;
    case (state_r)
      S_INIT: begin
        wr_en = 1'b1;
        wr_data = '0;
        row_nxt = row_r + 1'b1;
        if (row_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          if (in_ch.req_type == mhct_pkg::REQ_SWEEP) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            row_nxt   = '0;
            state_nxt = S_SWEEP;
          end else if (32'(in_ch.table_sel) >= 32'(TABLES)) begin
            res_st_nxt = mhct_pkg::ST_DROPPED;
            state_nxt  = S_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = in_row;
            row_nxt   = in_row;
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        wr_en      = 1'b1;
        res_st_nxt = acc_st;
        state_nxt  = S_DONE;
      end
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_data = swp_row;
        cnt_nxt = cnt_sum[mhct_pkg::COUNT_W] ? mhct_pkg::COUNT_MAX
                                             : cnt_sum[mhct_pkg::COUNT_W-1:0];
        if (row_r == LAST_ROW) begin
          res_st_nxt = mhct_pkg::ST_SWEPT;
          state_nxt  = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = row_r + 1'b1;
          row_nxt = row_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

  // Request payload and working result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mac_r <= in_ch.mac_addr;
      now_r <= in_ch.now_ms;
    end
    res_st_r <= res_st_nxt;
    cnt_r    <= cnt_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_cnt_r <= (res_st_r == mhct_pkg::ST_SWEPT) ? cnt_r : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.aged_count = out_cnt_r;

endmodule

[rtl/core/mac_hit_count_table_with_aging_top.sv]
// ----------------------------------------------------------------------------
// mac_hit_count_table_with_aging_top
// Hashed MAC tables with hit counting, release and age sweep.
// ----------------------------------------------------------------------------
// Access: the bucket row is read, then compared and written back, then the
//   result is loaded; the next request is taken only once the table is idle.
// Sweep: every bucket row is read and written back, one bucket row per cycle;
//   a held result stalls the next result until it is taken.
// Reset: a clearing pass writes every row (TABLES*BUCKETS rows), with no
//   request taken; configuration writes are taken throughout.
module mac_hit_count_table_with_aging_top #(
  parameter int BUCKETS = mhct_pkg::BUCKETS_DEF,
  parameter int TABLES  = mhct_pkg::TABLES_DEF,
  parameter int WAYS    = mhct_pkg::WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mhct_in_if.sink     in_ch,
  mhct_out_if.source  out_ch,
  mhct_cfg_if.sink    cfg_ch
);

  localparam int ROWS  = TABLES * BUCKETS;
  localparam int ROW_W = $clog2(ROWS);

  logic                         rd_en;
  logic [ROW_W-1:0]             rd_addr;
  mhct_pkg::entry_t [WAYS-1:0]  rd_data;
  logic                         wr_en;
  logic [ROW_W-1:0]             wr_addr;
  mhct_pkg::entry_t [WAYS-1:0]  wr_data;

  // Sequencer.
  mhct_ctrl #(
    .BUCKETS (BUCKETS),
    .TABLES  (TABLES),
    .WAYS    (WAYS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Bucket memory.
  mhct_mem #(
    .ROWS (ROWS),
    .WAYS (WAYS)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

[rtl/core/mhct_chk.sv]
// ----------------------------------------------------------------------------
// mhct_chk
// Port-level checks of the MAC hit count table, bound to the top level.
// ----------------------------------------------------------------------------
module mhct_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mhct_pkg::STATUS_W-1:0]   out_status,
  input logic [mhct_pkg::COUNT_W-1:0]    out_count
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  // Only defined status codes leave the block.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= mhct_pkg::ST_SWEPT)
    else $error("undefined status code");

  // Accesses never report a removal count.
  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mhct_pkg::ST_SWEPT |-> out_count == '0)
    else $error("nonzero count on an access result");

  // The clearing pass blocks requests right after reset.
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind mac_hit_count_table_with_aging_top mhct_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_count  (out_ch.aged_count)
);

[tb/sv/mhct_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mhct_tb_pkg
// Request and expected-result records shared by the table testbench.
// ----------------------------------------------------------------------------
package mhct_tb_pkg;

  // One request offered to the table.
  typedef struct packed {
    logic                            req_type;
    logic [mhct_pkg::TSEL_W-1:0]     table_sel;
    logic [mhct_pkg::MAC_W-1:0]      mac_addr;
    logic [mhct_pkg::TIME_W-1:0]     now_ms;
  } table_req_t;

  // One result expected back from the table.
  typedef struct packed {
    logic [mhct_pkg::STATUS_W-1:0]   status;
    logic [mhct_pkg::COUNT_W-1:0]    aged_count;
  } table_rsp_t;
endpackage

[tb/sv/mac_hit_count_table_with_aging_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MAC hit count table testbench
// Drives directed and random access and sweep requests through the request
// channel, predicts every result from a behavioral copy of the tables, and
// compares each result field by field. Register settings change between
// phases while the table is idle, and the result side stalls at random.
// ----------------------------------------------------------------------------
module mac_hit_count_table_with_aging_top_tb;

  localparam int NBUCKETS = mhct_pkg::BUCKETS_DEF;
  localparam int NTABLES  = mhct_pkg::TABLES_DEF;
  localparam int NWAYS    = mhct_pkg::WAYS_DEF;
  localparam int NENTRIES = NBUCKETS * NTABLES * NWAYS;
  localparam int SWEEP_CYCLES = NTABLES * NBUCKETS + 3;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst_n;

  mhct_in_if  in_ch();
  mhct_out_if out_ch();
  mhct_cfg_if cfg_ch();

  mac_hit_count_table_with_aging_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Predicted table contents and register copies.
  logic                          mdl_valid [NENTRIES];
  logic [mhct_pkg::MAC_W-1:0]    mdl_mac   [NENTRIES];
  logic [mhct_pkg::HITS_W-1:0]   mdl_hits  [NENTRIES];
  logic [mhct_pkg::TIME_W-1:0]   mdl_stamp [NENTRIES];
  logic [mhct_pkg::TIME_W-1:0]   mdl_age_limit;
  logic [mhct_pkg::HITS_W-1:0]   mdl_rel_hits;

  mhct_tb_pkg::table_req_t req_q[$];
  mhct_tb_pkg::table_rsp_t expected_rsp_q[$];

  int  mismatch_cnt;
  bit  hold_off_req;
  int  hold_off_left;
  longint cycle_cnt;

  // Recently inserted MACs, reused so that accesses hit.
  logic [mhct_pkg::MAC_W-1:0]  known_mac[$];
  logic [mhct_pkg::TSEL_W-1:0] known_tbl[$];
  logic [mhct_pkg::TIME_W-1:0] clock_ms;

  always #5 clk = ~clk;

  // Bucket index from the byte fold of the MAC.
  function automatic int bucket_index(input logic [mhct_pkg::MAC_W-1:0] mac);
    logic [31:0] x;
    x = {24'd0, mac[47:40]};
    for (int b = 4; b >= 0; b--) begin
      x = (x << 2) ^ {24'd0, mac[b*8 +: 8]};
    end
    x = x ^ (x >> 8);
    return int'(x & (NBUCKETS - 1));
  endfunction

  // Apply one request to the predicted tables and return its result.
  function automatic mhct_tb_pkg::table_rsp_t predict_table(
      input mhct_tb_pkg::table_req_t r);
    mhct_tb_pkg::table_rsp_t rsp;
    int base;
    int free_way;
    int removed;
    rsp = '0;
    free_way = -1;
    removed = 0;
    if (r.req_type == mhct_pkg::REQ_SWEEP) begin
      for (int i = 0; i < NENTRIES; i++) begin
        if (mdl_valid[i] && (r.now_ms < mdl_stamp[i] ||
            (r.now_ms - mdl_stamp[i]) >= mdl_age_limit)) begin
          mdl_valid[i] = 1'b0;
          removed++;
        end
      end
      rsp.status = mhct_pkg::ST_SWEPT;
      rsp.aged_count = (removed > 32767) ? mhct_pkg::COUNT_MAX
                                         : mhct_pkg::COUNT_W'(removed);
      return rsp;
    end
    if (int'(r.table_sel) >= NTABLES) begin
      rsp.status = mhct_pkg::ST_DROPPED;
      return rsp;
    end
    base = (int'(r.table_sel) * NBUCKETS + bucket_index(r.mac_addr)) * NWAYS;
    for (int w = 0; w < NWAYS; w++) begin
      if (mdl_valid[base+w] && mdl_mac[base+w] == r.mac_addr) begin
        mdl_hits[base+w] = mdl_hits[base+w] + 2'd1;
        if (mdl_hits[base+w] >= mdl_rel_hits) begin
          mdl_valid[base+w] = 1'b0;
          rsp.status = mhct_pkg::ST_RELEASED;
        end else begin
          rsp.status = mhct_pkg::ST_HIT;
        end
        return rsp;
      end
      if (!mdl_valid[base+w] && free_way < 0) free_way = w;
    end
    if (free_way < 0) begin
      rsp.status = mhct_pkg::ST_DROPPED;
      return rsp;
    end
    mdl_valid[base+free_way] = 1'b1;
    mdl_mac[base+free_way]   = r.mac_addr;
    mdl_hits[base+free_way]  = '0;
    mdl_stamp[base+free_way] = r.now_ms;
    rsp.status = mhct_pkg::ST_INSERTED;
    return rsp;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsp_q.push_back(predict_table(req_q.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current request until taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req_q[0].req_type;
        in_ch.table_sel <= req_q[0].table_sel;
        in_ch.mac_addr  <= req_q[0].mac_addr;
        in_ch.now_ms    <= req_q[0].now_ms;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall pattern plus an optional long hold-off.
  logic [3:0] stall_pat;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pat <= 4'b0;
      hold_off_left <= 0;
    end else begin
      if (hold_off_req && hold_off_left == 0) hold_off_left <= 300;
      else if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
      if ($urandom_range(31, 0) == 0) stall_pat <= 4'($urandom);
      out_ch.ready <= (hold_off_left > 1) ? 1'b0 :
                      !stall_pat[$urandom_range(3, 0)] || stall_pat == 4'b0;
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    mhct_tb_pkg::table_rsp_t exp_rsp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsp_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected result status=%0d count=%0d", out_ch.status,
                   out_ch.aged_count);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_ch.status !== exp_rsp.status ||
            out_ch.aged_count !== exp_rsp.aged_count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Result mismatch: expected status=%0d count=%0d, got %0d %0d",
                     exp_rsp.status, exp_rsp.aged_count, out_ch.status,
                     out_ch.aged_count);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Queue one request.
  task automatic add_req(input logic rt, input logic [mhct_pkg::TSEL_W-1:0] ts,
                         input logic [mhct_pkg::MAC_W-1:0] mac,
                         input logic [mhct_pkg::TIME_W-1:0] t);
    mhct_tb_pkg::table_req_t r;
    r.req_type = rt;
    r.table_sel = ts;
    r.mac_addr = mac;
    r.now_ms = t;
    req_q.push_back(r);
  endtask

  // Write one register while the table is idle, then drop the write.
  task automatic write_reg(input logic [mhct_pkg::CIDX_W-1:0] idx,
                           input logic [mhct_pkg::CDATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == mhct_pkg::REG_AGE_LIMIT) mdl_age_limit = val;
    else if (idx == mhct_pkg::REG_REL_HITS) mdl_rel_hits = val[mhct_pkg::HITS_W-1:0];
    @(posedge clk);
  endtask

  // Wait until every queued request has been answered.
  task automatic drain();
    while (req_q.size() > 0 || in_ch.valid || expected_rsp_q.size() > 0)
      @(posedge clk);
    repeat (SWEEP_CYCLES + 20) @(posedge clk);
  endtask

  // Random traffic: reused and new MACs in about equal share, rare sweeps, some noise.
  task automatic random_phase(input int count);
    logic [mhct_pkg::MAC_W-1:0] mac;
    logic [mhct_pkg::TSEL_W-1:0] ts;
    int k;
    int pick;
    for (int n = 0; n < count; n++) begin
      clock_ms = clock_ms + $urandom_range(3000, 0);
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        add_req(mhct_pkg::REQ_SWEEP, 2'($urandom), 48'({$urandom, $urandom}),
                ($urandom_range(9, 0) == 0) ? $urandom : clock_ms);
      end else if (pick < 50 && known_mac.size() > 0) begin
        k = $urandom_range(known_mac.size() - 1, 0);
        add_req(mhct_pkg::REQ_ACCESS, known_tbl[k], known_mac[k], clock_ms);
      end else begin
        // Low-entropy MACs crowd buckets so that some fill up.
        if ($urandom_range(1, 0)) mac = 48'({$urandom, $urandom});
        else mac = {40'd0, 8'($urandom)} << (8 * $urandom_range(5, 0));
        ts = 2'($urandom);
        add_req(mhct_pkg::REQ_ACCESS, ts, mac,
                ($urandom_range(19, 0) == 0) ? $urandom : clock_ms);
        known_mac.push_back(mac);
        known_tbl.push_back(ts);
        if (known_mac.size() > 64) begin
          void'(known_mac.pop_front());
          void'(known_tbl.pop_front());
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    hold_off_req = 1'b0;
    clock_ms = 32'd1000;
    in_ch.valid = 1'b0;
    in_ch.req_type = mhct_pkg::REQ_ACCESS;
    in_ch.table_sel = '0;
    in_ch.mac_addr = '0;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    mdl_age_limit = mhct_pkg::AGE_LIMIT_RST;
    mdl_rel_hits = mhct_pkg::REL_HITS_RST;
    for (int i = 0; i < NENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_mac[i] = '0;
      mdl_hits[i] = '0;
      mdl_stamp[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: insert, hit, release, full bucket, extremes, sweeps.
    add_req(mhct_pkg::REQ_ACCESS, 2'd0, 48'h0, 32'd0);
    add_req(mhct_pkg::REQ_ACCESS, 2'd0, 48'h0, 32'd5);
    add_req(mhct_pkg::REQ_ACCESS, 2'd0, 48'h0, 32'd6);
    add_req(mhct_pkg::REQ_ACCESS, 2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    add_req(mhct_pkg::REQ_ACCESS, 2'd3, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    // Five MACs whose first two bytes cancel in the fold, so all land in
    // bucket zero: the fifth is dropped.
    for (int i = 0; i < 5; i++)
      add_req(mhct_pkg::REQ_ACCESS, 2'd1, 48'h0 | (48'(i) << 40) | (48'(i) << 34),
              32'd100);
    add_req(mhct_pkg::REQ_ACCESS, 2'd2, 48'hA5A5_5A5A_A5A5, 32'd20000);
    add_req(mhct_pkg::REQ_SWEEP, 2'd0, 48'h0, 32'd20000);
    add_req(mhct_pkg::REQ_ACCESS, 2'd2, 48'h1234_5678_9ABC, 32'd0);
    add_req(mhct_pkg::REQ_SWEEP, 2'd3, 48'hFFFF_FFFF_FFFF, 32'd10);
    drain();

    // Zero age limit and immediate release: every sweep empties the tables.
    write_reg(mhct_pkg::REG_AGE_LIMIT, 32'd0);
    write_reg(mhct_pkg::REG_REL_HITS, 32'd0);
    add_req(mhct_pkg::REQ_ACCESS, 2'd1, 48'h0102_0304_0506, 32'd50);
    add_req(mhct_pkg::REQ_ACCESS, 2'd1, 48'h0102_0304_0506, 32'd50);
    add_req(mhct_pkg::REQ_ACCESS, 2'd2, 48'h0102_0304_0506, 32'd50);
    add_req(mhct_pkg::REQ_SWEEP, 2'd0, 48'h0, 32'd50);
    random_phase(300);
    drain();

    // Largest limit and threshold, with a long hold-off on the result side.
    write_reg(mhct_pkg::REG_AGE_LIMIT, 32'hFFFF_FFFF);
    write_reg(mhct_pkg::REG_REL_HITS, 32'd3);
    hold_off_req = 1'b1;
    random_phase(600);
    @(posedge clk);
    hold_off_req = 1'b0;
    drain();

    // Single-hit release with a mid-range limit.
    write_reg(mhct_pkg::REG_AGE_LIMIT, 32'd4000);
    write_reg(mhct_pkg::REG_REL_HITS, 32'd1);
    random_phase(500);
    drain();

    // Back to the reset-like setting.
    write_reg(mhct_pkg::REG_AGE_LIMIT, 32'd15000);
    write_reg(mhct_pkg::REG_REL_HITS, 32'd2);
    random_phase(480);
    drain();

    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
